@@ design/disk_controller_command_ports_defines.svh @@
`ifndef DISK_CONTROLLER_COMMAND_PORTS_DEFINES_SVH
`define DISK_CONTROLLER_COMMAND_PORTS_DEFINES_SVH

// same-cycle implication
`define DCCP_ASSERT_SAME(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("dccp check failed");

// next-cycle implication
`define DCCP_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("dccp check failed");

`endif

@@ design/dccp_pkg.sv @@
package dccp_pkg;

    localparam logic [2:0] FUNC_CMD_WRITE = 3'd0;
    localparam logic [2:0] FUNC_CMD_READ  = 3'd1;
    localparam logic [2:0] FUNC_A_WRITE   = 3'd2;
    localparam logic [2:0] FUNC_A_READ    = 3'd3;
    localparam logic [2:0] FUNC_B_WRITE   = 3'd4;
    localparam logic [2:0] FUNC_B_READ    = 3'd5;
    localparam logic [2:0] FUNC_DONE      = 3'd6;

    localparam logic [31:0] CMD_SELECT          = 32'd1;
    localparam logic [31:0] CMD_START_READ      = 32'd2;
    localparam logic [31:0] CMD_START_WRITE     = 32'd3;
    localparam logic [31:0] CMD_FETCH_COMPLETED = 32'd4;
    localparam logic [31:0] CMD_POLL            = 32'd5;
    localparam logic [31:0] CMD_IRQ_ON          = 32'd6;
    localparam logic [31:0] CMD_IRQ_OFF         = 32'd7;
    localparam logic [31:0] CMD_SET_COUNT       = 32'd8;
    localparam logic [31:0] CMD_SET_ADDRESS     = 32'd9;

    localparam logic [2:0] CFG_DRIVE_PRESENT  = 3'd0;
    localparam logic [2:0] CFG_SECTOR_COUNT_0 = 3'd1;
    localparam logic [2:0] CFG_ASYNC_MODE     = 3'd5;

    localparam int MAX_DRIVES  = 4;
    localparam int MAX_COUNT   = 8;
    localparam int SECTOR_BITS = 9;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        OP_NOP,
        OP_READ_BUSY,
        OP_WRITE_A,
        OP_READ_A,
        OP_WRITE_B,
        OP_READ_B,
        OP_DONE,
        OP_SELECT,
        OP_START_READ,
        OP_START_WRITE,
        OP_FETCH_COMPLETED,
        OP_POLL,
        OP_IRQ_ON,
        OP_IRQ_OFF,
        OP_SET_COUNT,
        OP_SET_ADDRESS
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] data;
        logic [1:0]  drive;
    } entry_t;

    typedef struct packed {
        logic        bus_error;
        logic [31:0] read_data;
        logic        xfer_start;
        logic        xfer_is_write;
        logic [1:0]  xfer_drive;
        logic [31:0] xfer_sector;
        logic [31:0] xfer_address;
        logic [3:0]  xfer_count;
        logic        irq;
    } result_t;

endpackage

@@ design/dccp_req_if.sv @@
interface dccp_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [31:0] write_data;
    logic [1:0]  event_drive;

    modport source (output valid, output func, output write_data, output event_drive,
                    input ready);
    modport sink (input valid, input func, input write_data, input event_drive,
                  output ready);
endinterface

@@ design/dccp_rsp_if.sv @@
interface dccp_rsp_if;
    logic        valid;
    logic        ready;
    logic        bus_error;
    logic [31:0] read_data;
    logic        xfer_start;
    logic        xfer_is_write;
    logic [1:0]  xfer_drive;
    logic [31:0] xfer_sector;
    logic [31:0] xfer_address;
    logic [3:0]  xfer_count;
    logic        irq;

    modport source (output valid, output bus_error, output read_data, output xfer_start,
                    output xfer_is_write, output xfer_drive, output xfer_sector,
                    output xfer_address, output xfer_count, output irq, input ready);
    modport sink (input valid, input bus_error, input read_data, input xfer_start,
                  input xfer_is_write, input xfer_drive, input xfer_sector,
                  input xfer_address, input xfer_count, input irq, output ready);
endinterface

@@ design/dccp_cfg_if.sv @@
interface dccp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/dccp_front.sv @@
module dccp_front
(
    dccp_req_if.sink          req,
    input  logic              queue_full,
    output logic              push_valid,
    output dccp_pkg::entry_t  push_entry
);

    assign req.ready  = !queue_full;
    assign push_valid = req.valid && !queue_full;

    always_comb
    begin
        push_entry.data  = req.write_data;
        push_entry.drive = req.event_drive;
        unique case (req.func)
            dccp_pkg::FUNC_CMD_WRITE:
            begin
                unique case (req.write_data)
                    dccp_pkg::CMD_SELECT:          push_entry.op = dccp_pkg::OP_SELECT;
                    dccp_pkg::CMD_START_READ:      push_entry.op = dccp_pkg::OP_START_READ;
                    dccp_pkg::CMD_START_WRITE:     push_entry.op = dccp_pkg::OP_START_WRITE;
                    dccp_pkg::CMD_FETCH_COMPLETED: push_entry.op = dccp_pkg::OP_FETCH_COMPLETED;
                    dccp_pkg::CMD_POLL:            push_entry.op = dccp_pkg::OP_POLL;
                    dccp_pkg::CMD_IRQ_ON:          push_entry.op = dccp_pkg::OP_IRQ_ON;
                    dccp_pkg::CMD_IRQ_OFF:         push_entry.op = dccp_pkg::OP_IRQ_OFF;
                    dccp_pkg::CMD_SET_COUNT:       push_entry.op = dccp_pkg::OP_SET_COUNT;
                    dccp_pkg::CMD_SET_ADDRESS:     push_entry.op = dccp_pkg::OP_SET_ADDRESS;
                    default:                       push_entry.op = dccp_pkg::OP_NOP;
                endcase
            end
            dccp_pkg::FUNC_CMD_READ: push_entry.op = dccp_pkg::OP_READ_BUSY;
            dccp_pkg::FUNC_A_WRITE:  push_entry.op = dccp_pkg::OP_WRITE_A;
            dccp_pkg::FUNC_A_READ:   push_entry.op = dccp_pkg::OP_READ_A;
            dccp_pkg::FUNC_B_WRITE:  push_entry.op = dccp_pkg::OP_WRITE_B;
            dccp_pkg::FUNC_B_READ:   push_entry.op = dccp_pkg::OP_READ_B;
            dccp_pkg::FUNC_DONE:     push_entry.op = dccp_pkg::OP_DONE;
            default:                 push_entry.op = dccp_pkg::OP_NOP;
        endcase
    end

endmodule

@@ design/dccp_queue.sv @@
module dccp_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    input  dccp_pkg::entry_t  push_entry,
    output logic              queue_full,
    input  logic              pop,
    output logic              entry_valid,
    output dccp_pkg::entry_t  head_entry
);

    dccp_pkg::entry_t                  slot_reg [dccp_pkg::QUEUE_DEPTH];
    logic [dccp_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [dccp_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [dccp_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [dccp_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [dccp_pkg::QCNT_W-1:0]       fill_reg;
    logic [dccp_pkg::QCNT_W-1:0]       fill_next;
    logic                              do_push;
    logic                              do_pop;

    assign queue_full  = (fill_reg == dccp_pkg::QCNT_W'(dccp_pkg::QUEUE_DEPTH));
    assign entry_valid = (fill_reg != '0);
    assign head_entry  = slot_reg[rd_ptr_reg];
    assign do_push     = push_valid && !queue_full;
    assign do_pop      = pop && entry_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == dccp_pkg::QPTR_W'(dccp_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == dccp_pkg::QPTR_W'(dccp_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ design/dccp_back.sv @@
module dccp_back
#(
    parameter int NUM_DRIVES = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              entry_valid,
    input  dccp_pkg::entry_t  head_entry,
    output logic              pop,
    dccp_cfg_if.sink          cfg,
    dccp_rsp_if.source        rsp
);

    // configuration
    logic [3:0]  present_reg;
    logic [31:0] sectors_reg [NUM_DRIVES];
    logic        async_reg;

    // controller state
    logic [31:0] port_a_reg;
    logic [31:0] port_a_next;
    logic [31:0] port_b_reg;
    logic [31:0] port_b_next;
    logic        selected_reg;
    logic        selected_next;
    logic [1:0]  sel_drive_reg;
    logic [1:0]  sel_drive_next;
    logic [3:0]  busy_reg;
    logic [3:0]  busy_next;
    logic [3:0]  completed_reg;
    logic [3:0]  completed_next;
    logic        irq_en_reg;
    logic        irq_en_next;
    logic [3:0]  count_reg;
    logic [3:0]  count_next;
    logic [31:dccp_pkg::SECTOR_BITS] addr_reg;
    logic [31:dccp_pkg::SECTOR_BITS] addr_next;

    // output word
    logic                 out_valid_reg;
    logic                 out_valid_next;
    dccp_pkg::result_t    out_reg;
    dccp_pkg::result_t    out_next;

    logic [31:0] sel_sectors;
    logic [31:0] poll_sectors;
    logic        port_a_ok;
    logic [32:0] end_sum;
    logic [3:0]  sel_bit;
    logic [3:0]  ev_bit;
    logic        ev_ok;
    logic        start_ok;

    assign cfg.ready = 1'b1;
    assign pop       = entry_valid && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        sel_sectors  = '0;
        poll_sectors = '0;
        for (int i = 0; i < NUM_DRIVES; i++)
        begin
            if (sel_drive_reg == 2'(i))
            begin
                sel_sectors = sectors_reg[i];
            end
            if (port_a_reg[1:0] == 2'(i))
            begin
                poll_sectors = sectors_reg[i];
            end
        end
    end

    assign port_a_ok = (port_a_reg[31:2] == '0)
                       && ({1'b0, port_a_reg[1:0]} < 3'(NUM_DRIVES))
                       && present_reg[port_a_reg[1:0]];
    assign end_sum   = {1'b0, port_a_reg} + 33'(count_reg);
    assign sel_bit   = 4'b0001 << sel_drive_reg;
    assign ev_bit    = 4'b0001 << head_entry.drive;
    assign ev_ok     = ({1'b0, head_entry.drive} < 3'(NUM_DRIVES))
                       && busy_reg[head_entry.drive];
    assign start_ok  = selected_reg && !end_sum[32]
                       && (end_sum[31:0] < sel_sectors)
                       && ((busy_reg & sel_bit) == '0);

    always_comb
    begin
        port_a_next    = port_a_reg;
        port_b_next    = port_b_reg;
        selected_next  = selected_reg;
        sel_drive_next = sel_drive_reg;
        busy_next      = busy_reg;
        completed_next = completed_reg;
        irq_en_next    = irq_en_reg;
        count_next     = count_reg;
        addr_next      = addr_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (pop)
        begin
            out_valid_next = 1'b1;
            out_next       = '0;
            case (head_entry.op)
                dccp_pkg::OP_READ_BUSY: out_next.read_data = 32'(busy_reg);
                dccp_pkg::OP_WRITE_A:   port_a_next = head_entry.data;
                dccp_pkg::OP_READ_A:    out_next.read_data = port_a_reg;
                dccp_pkg::OP_WRITE_B:   port_b_next = head_entry.data;
                dccp_pkg::OP_READ_B:    out_next.read_data = port_b_reg;
                dccp_pkg::OP_DONE:
                begin
                    if (ev_ok)
                    begin
                        busy_next      = busy_reg & ~ev_bit;
                        completed_next = completed_reg | ev_bit;
                        out_next.irq   = irq_en_reg;
                    end
                end
                dccp_pkg::OP_SELECT:
                begin
                    selected_next  = port_a_ok;
                    sel_drive_next = port_a_ok ? port_a_reg[1:0] : 2'd0;
                end
                dccp_pkg::OP_START_READ, dccp_pkg::OP_START_WRITE:
                begin
                    if (start_ok)
                    begin
                        out_next.xfer_start    = 1'b1;
                        out_next.xfer_is_write = (head_entry.op == dccp_pkg::OP_START_WRITE);
                        out_next.xfer_drive    = sel_drive_reg;
                        out_next.xfer_sector   = port_a_reg;
                        out_next.xfer_address  = {addr_reg, dccp_pkg::SECTOR_BITS'(0)};
                        out_next.xfer_count    = count_reg;
                        if (async_reg)
                        begin
                            busy_next = busy_reg | sel_bit;
                        end
                        else
                        begin
                            completed_next = completed_reg | sel_bit;
                            out_next.irq   = irq_en_reg;
                        end
                    end
                    else
                    begin
                        out_next.bus_error = 1'b1;
                    end
                end
                dccp_pkg::OP_FETCH_COMPLETED:
                begin
                    port_a_next    = '0;
                    port_b_next    = 32'(completed_reg);
                    completed_next = '0;
                end
                dccp_pkg::OP_POLL:
                begin
                    port_a_next = port_a_ok ? 32'd1 : 32'd0;
                    port_b_next = port_a_ok ? poll_sectors : 32'd0;
                end
                dccp_pkg::OP_IRQ_ON:  irq_en_next = 1'b1;
                dccp_pkg::OP_IRQ_OFF: irq_en_next = 1'b0;
                dccp_pkg::OP_SET_COUNT:
                begin
                    if ((port_a_reg == '0) || (port_a_reg > 32'(dccp_pkg::MAX_COUNT)))
                    begin
                        out_next.bus_error = 1'b1;
                    end
                    else
                    begin
                        count_next = port_a_reg[3:0];
                    end
                end
                dccp_pkg::OP_SET_ADDRESS: addr_next = port_a_reg[31:dccp_pkg::SECTOR_BITS];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_a_reg    <= '0;
            port_b_reg    <= '0;
            selected_reg  <= 1'b0;
            sel_drive_reg <= '0;
            busy_reg      <= '0;
            completed_reg <= '0;
            irq_en_reg    <= 1'b0;
            count_reg     <= '0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            port_a_reg    <= port_a_next;
            port_b_reg    <= port_b_next;
            selected_reg  <= selected_next;
            sel_drive_reg <= sel_drive_next;
            busy_reg      <= busy_next;
            completed_reg <= completed_next;
            irq_en_reg    <= irq_en_next;
            count_reg     <= count_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            async_reg   <= 1'b0;
            for (int i = 0; i < NUM_DRIVES; i++)
            begin
                sectors_reg[i] <= '0;
            end
        end
        else if (cfg.valid)
        begin
            if (cfg.index == dccp_pkg::CFG_DRIVE_PRESENT)
            begin
                present_reg <= cfg.data[3:0];
            end
            if (cfg.index == dccp_pkg::CFG_ASYNC_MODE)
            begin
                async_reg <= cfg.data[0];
            end
            for (int i = 0; i < NUM_DRIVES; i++)
            begin
                if (cfg.index == dccp_pkg::CFG_SECTOR_COUNT_0 + 3'(i))
                begin
                    sectors_reg[i] <= cfg.data;
                end
            end
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.bus_error     = out_reg.bus_error;
    assign rsp.read_data     = out_reg.read_data;
    assign rsp.xfer_start    = out_reg.xfer_start;
    assign rsp.xfer_is_write = out_reg.xfer_is_write;
    assign rsp.xfer_drive    = out_reg.xfer_drive;
    assign rsp.xfer_sector   = out_reg.xfer_sector;
    assign rsp.xfer_address  = out_reg.xfer_address;
    assign rsp.xfer_count    = out_reg.xfer_count;
    assign rsp.irq           = out_reg.irq;

endmodule

@@ design/disk_controller_command_ports.sv @@
// an accepted access is stored in the queue, then executed into the output register; an output stall holds it back
// throughput: one access per cycle while the response side is ready, set by the execute stage and output register
// a two-word queue between decode and execute absorbs output backpressure
// configuration writes are registered and always ready
// reset clears all controller state, configuration, queue pointers and output register at once
`include "disk_controller_command_ports_defines.svh"

module disk_controller_command_ports
#(
    parameter int NUM_DRIVES = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    dccp_req_if.sink     req,
    dccp_rsp_if.source   rsp,
    dccp_cfg_if.sink     cfg
);

    logic              queue_full;
    logic              push_valid;
    dccp_pkg::entry_t  push_entry;
    logic              pop;
    logic              entry_valid;
    dccp_pkg::entry_t  head_entry;

    dccp_front u_front
    (
        .req        (req),
        .queue_full (queue_full),
        .push_valid (push_valid),
        .push_entry (push_entry)
    );

    dccp_queue u_queue
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_valid  (push_valid),
        .push_entry  (push_entry),
        .queue_full  (queue_full),
        .pop         (pop),
        .entry_valid (entry_valid),
        .head_entry  (head_entry)
    );

    dccp_back #(.NUM_DRIVES(NUM_DRIVES)) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (entry_valid),
        .head_entry  (head_entry),
        .pop         (pop),
        .cfg         (cfg),
        .rsp         (rsp)
    );

    `DCCP_ASSERT_SAME(a_start_no_error, rsp.valid && rsp.xfer_start, !rsp.bus_error)
    `DCCP_ASSERT_SAME(a_idle_xfer_zero, rsp.valid && !rsp.xfer_start, (rsp.xfer_count == 4'd0) && (rsp.xfer_address == 32'd0))
    `DCCP_ASSERT_SAME(a_addr_aligned, rsp.valid, rsp.xfer_address[8:0] == 9'd0)
    `DCCP_ASSERT_SAME(a_queue_consistent, !entry_valid, !queue_full && !pop)

endmodule

@@ dv/tb_top.sv @@
module tb_top;

    localparam int DRIVES = 4;
    localparam logic [2:0] FUNC_UNUSED = 3'd7;
    localparam logic [31:0] CMD_UNKNOWN = 32'hFFFF_FFFF;

    logic clk;
    logic rst_n;

    dccp_req_if req();
    dccp_rsp_if rsp();
    dccp_cfg_if cfg();

    disk_controller_command_ports #(.NUM_DRIVES(DRIVES)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    // controller state as seen from the bus
    logic [3:0]  present;
    logic [31:0] sectors [4];
    logic        async_on;
    logic [31:0] pa;
    logic [31:0] pb;
    logic        sel_valid;
    logic [1:0]  sel_drive;
    logic [3:0]  busy;
    logic [3:0]  done_mask;
    logic        irq_en;
    logic [3:0]  xfer_cnt;
    logic [31:0] xfer_addr;

    dccp_pkg::result_t awaited_responses [$];
    int      fault_count = 0;
    int      sent_count = 0;
    bit      quiet = 1'b0;
    int      hold_len = 0;

    function automatic logic finish_transfer(input logic [1:0] drv);
        busy[drv] = 1'b0;
        done_mask[drv] = 1'b1;
        return irq_en;
    endfunction

    function automatic dccp_pkg::result_t compute_response(input logic [2:0] f,
                                                           input logic [31:0] d,
                                                           input logic [1:0] ev);
        dccp_pkg::result_t r;
        logic [32:0] sum;
        r = '0;
        case (f)
            dccp_pkg::FUNC_CMD_WRITE:
                case (d)
                    dccp_pkg::CMD_SELECT:
                        if (pa < DRIVES && present[pa[1:0]])
                        begin
                            sel_valid = 1'b1;
                            sel_drive = pa[1:0];
                        end
                        else
                        begin
                            sel_valid = 1'b0;
                            sel_drive = 2'd0;
                        end
                    dccp_pkg::CMD_START_READ, dccp_pkg::CMD_START_WRITE:
                        if (!sel_valid)
                        begin
                            r.bus_error = 1'b1;
                        end
                        else
                        begin
                            sum = {1'b0, pa} + {29'd0, xfer_cnt};
                            if (sum[32] || sum[31:0] >= sectors[sel_drive] || busy[sel_drive])
                            begin
                                r.bus_error = 1'b1;
                            end
                            else
                            begin
                                busy[sel_drive] = 1'b1;
                                r.xfer_start = 1'b1;
                                r.xfer_is_write = (d == dccp_pkg::CMD_START_WRITE);
                                r.xfer_drive = sel_drive;
                                r.xfer_sector = pa;
                                r.xfer_address = xfer_addr;
                                r.xfer_count = xfer_cnt;
                                if (!async_on)
                                    r.irq = finish_transfer(sel_drive);
                            end
                        end
                    dccp_pkg::CMD_FETCH_COMPLETED:
                    begin
                        pa = 32'd0;
                        pb = {28'd0, done_mask};
                        done_mask = 4'd0;
                    end
                    dccp_pkg::CMD_POLL:
                        if (pa < DRIVES && present[pa[1:0]])
                        begin
                            pb = sectors[pa[1:0]];
                            pa = 32'd1;
                        end
                        else
                        begin
                            pa = 32'd0;
                            pb = 32'd0;
                        end
                    dccp_pkg::CMD_IRQ_ON:  irq_en = 1'b1;
                    dccp_pkg::CMD_IRQ_OFF: irq_en = 1'b0;
                    dccp_pkg::CMD_SET_COUNT:
                        if (pa == 32'd0 || pa > dccp_pkg::MAX_COUNT)
                            r.bus_error = 1'b1;
                        else
                            xfer_cnt = pa[3:0];
                    dccp_pkg::CMD_SET_ADDRESS:
                        xfer_addr = {pa[31:dccp_pkg::SECTOR_BITS],
                                     {dccp_pkg::SECTOR_BITS{1'b0}}};
                    default: ;
                endcase
            dccp_pkg::FUNC_CMD_READ: r.read_data = {28'd0, busy};
            dccp_pkg::FUNC_A_WRITE:  pa = d;
            dccp_pkg::FUNC_A_READ:   r.read_data = pa;
            dccp_pkg::FUNC_B_WRITE:  pb = d;
            dccp_pkg::FUNC_B_READ:   r.read_data = pb;
            dccp_pkg::FUNC_DONE:
                if (ev < DRIVES && busy[ev])
                    r.irq = finish_transfer(ev);
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_access(input logic [2:0] f, input logic [31:0] d,
                               input logic [1:0] ev);
        @(negedge clk);
        while (!quiet && $urandom_range(0, 99) < 13)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.func <= f;
        req.write_data <= d;
        req.event_drive <= ev;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        awaited_responses.push_back(compute_response(f, d, ev));
        sent_count++;
    endtask

    task automatic send_cmd(input logic [31:0] code);
        send_access(dccp_pkg::FUNC_CMD_WRITE, code, 2'($urandom));
    endtask

    task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        if (idx == dccp_pkg::CFG_DRIVE_PRESENT)
            present = val[3:0];
        else if (idx >= dccp_pkg::CFG_SECTOR_COUNT_0 && idx < dccp_pkg::CFG_SECTOR_COUNT_0 + 3'd4)
            sectors[idx - dccp_pkg::CFG_SECTOR_COUNT_0] = val;
        else if (idx == dccp_pkg::CFG_ASYNC_MODE)
            async_on = val[0];
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic drain;
        @(negedge clk);
        req.valid <= 1'b0;
        while (awaited_responses.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input logic [3:0] mask, input logic [31:0] s0, input logic [31:0] s1,
                             input logic [31:0] s2, input logic [31:0] s3, input logic mode);
        drain();
        set_reg(dccp_pkg::CFG_DRIVE_PRESENT, {28'd0, mask});
        set_reg(dccp_pkg::CFG_SECTOR_COUNT_0, s0);
        set_reg(dccp_pkg::CFG_SECTOR_COUNT_0 + 3'd1, s1);
        set_reg(dccp_pkg::CFG_SECTOR_COUNT_0 + 3'd2, s2);
        set_reg(dccp_pkg::CFG_SECTOR_COUNT_0 + 3'd3, s3);
        set_reg(dccp_pkg::CFG_ASYNC_MODE, {31'd0, mode});
    endtask

    task automatic run_traffic(input int n);
        int target;
        int pick;
        logic [31:0] drv;
        logic [31:0] sector;
        target = sent_count + n;
        while (sent_count < target)
        begin
            pick = $urandom_range(0, 99);
            drv = ($urandom_range(0, 19) < 17) ? $urandom_range(0, 3) :
                  ($urandom_range(0, 1) ? $urandom_range(4, 7) : $urandom);
            if (pick < 45)
            begin
                // transfer attempt: select, optional count and address, start
                send_access(dccp_pkg::FUNC_A_WRITE, drv, 2'($urandom));
                send_cmd(dccp_pkg::CMD_SELECT);
                if ($urandom_range(0, 1))
                begin
                    send_access(dccp_pkg::FUNC_A_WRITE, $urandom_range(0, 9), 2'($urandom));
                    send_cmd(dccp_pkg::CMD_SET_COUNT);
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    send_access(dccp_pkg::FUNC_A_WRITE, $urandom, 2'($urandom));
                    send_cmd(dccp_pkg::CMD_SET_ADDRESS);
                end
                case ($urandom_range(0, 9))
                    0, 1:    sector = 32'hFFFF_FFFF - $urandom_range(0, 9);
                    2, 3, 4: sector = $urandom_range(0, 40);
                    default: sector = sectors[sel_drive] - xfer_cnt - 2 + $urandom_range(0, 2);
                endcase
                send_access(dccp_pkg::FUNC_A_WRITE, sector, 2'($urandom));
                send_cmd($urandom_range(0, 1) ? dccp_pkg::CMD_START_WRITE
                                              : dccp_pkg::CMD_START_READ);
                if (async_on && $urandom_range(0, 1))
                    send_access(dccp_pkg::FUNC_DONE, $urandom, sel_drive);
            end
            else if (pick < 60)
            begin
                send_access(dccp_pkg::FUNC_DONE, $urandom, 2'($urandom));
            end
            else if (pick < 68)
            begin
                send_access(dccp_pkg::FUNC_A_WRITE, drv, 2'($urandom));
                send_cmd(dccp_pkg::CMD_POLL);
                send_access(dccp_pkg::FUNC_B_READ, $urandom, 2'($urandom));
                send_access(dccp_pkg::FUNC_A_READ, $urandom, 2'($urandom));
            end
            else if (pick < 75)
            begin
                send_cmd(dccp_pkg::CMD_FETCH_COMPLETED);
                send_access(dccp_pkg::FUNC_B_READ, $urandom, 2'($urandom));
            end
            else if (pick < 82)
            begin
                send_cmd($urandom_range(0, 1) ? dccp_pkg::CMD_IRQ_ON : dccp_pkg::CMD_IRQ_OFF);
            end
            else if (pick < 88)
            begin
                send_access(dccp_pkg::FUNC_CMD_READ, $urandom, 2'($urandom));
            end
            else
            begin
                // noise over every func and data value
                send_access(3'($urandom_range(0, 7)),
                            $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom,
                            2'($urandom));
            end
        end
    endtask

    task automatic test_directed;
        configure(4'b1011, 32'hFFFF_FFFF, 32'd16, 32'd7, 32'd0, 1'b1);
        send_access(dccp_pkg::FUNC_A_WRITE, 32'hFFFF_FFFF, 2'd0);
        send_access(dccp_pkg::FUNC_A_READ, 32'd0, 2'd0);
        send_access(dccp_pkg::FUNC_B_WRITE, 32'd0, 2'd3);
        send_access(dccp_pkg::FUNC_B_READ, 32'hFFFF_FFFF, 2'd3);
        send_access(FUNC_UNUSED, 32'hFFFF_FFFF, 2'd3);
        send_cmd(CMD_UNKNOWN);
        send_cmd(dccp_pkg::CMD_SELECT);
        send_cmd(dccp_pkg::CMD_START_READ);
        send_access(dccp_pkg::FUNC_A_WRITE, 32'd1, 2'd0);
        send_cmd(dccp_pkg::CMD_POLL);
        send_cmd(dccp_pkg::CMD_SELECT);
        send_access(dccp_pkg::FUNC_A_WRITE, 32'd15, 2'd0);
        // count never set
        send_cmd(dccp_pkg::CMD_START_WRITE);
        send_cmd(dccp_pkg::CMD_START_READ);
        send_access(dccp_pkg::FUNC_CMD_READ, 32'd0, 2'd0);
        send_cmd(dccp_pkg::CMD_IRQ_ON);
        send_access(dccp_pkg::FUNC_DONE, 32'd0, 2'd2);
        send_access(dccp_pkg::FUNC_DONE, 32'd0, 2'd1);
        send_access(dccp_pkg::FUNC_A_WRITE, 32'd8, 2'd0);
        send_cmd(dccp_pkg::CMD_SET_COUNT);
        // past the end of the disk
        send_cmd(dccp_pkg::CMD_START_READ);
        send_access(dccp_pkg::FUNC_A_WRITE, 32'd0, 2'd0);
        send_cmd(dccp_pkg::CMD_SELECT);
        send_access(dccp_pkg::FUNC_A_WRITE, 32'hFFFF_FFFF, 2'd0);
        send_cmd(dccp_pkg::CMD_SET_ADDRESS);
        // sector plus count wraps
        send_cmd(dccp_pkg::CMD_START_READ);
        send_cmd(dccp_pkg::CMD_FETCH_COMPLETED);
        send_access(dccp_pkg::FUNC_B_READ, 32'd0, 2'd0);
        send_cmd(dccp_pkg::CMD_SET_COUNT);
        send_cmd(dccp_pkg::CMD_IRQ_OFF);
    endtask

    task automatic test_sync_transfers;
        configure(4'hF, $urandom_range(1, 40), $urandom_range(1, 40), $urandom_range(1, 40),
                  $urandom_range(1, 40), 1'b0);
        run_traffic(200);
    endtask

    task automatic test_async_transfers;
        configure(4'($urandom_range(1, 15)), 32'd0, 32'hFFFF_FFFF, $urandom_range(1, 20),
                  $urandom_range(1, 20), 1'b1);
        run_traffic(200);
    endtask

    task automatic test_mode_switch;
        // drives left busy by the async phase still wait for done
        configure(present, sectors[0], sectors[1], sectors[2], sectors[3], 1'b0);
        quiet = 1'b1;
        run_traffic(150);
        quiet = 1'b0;
    endtask

    task automatic test_no_drives;
        configure(4'h0, $urandom, $urandom, $urandom, $urandom, 1'b1);
        run_traffic(100);
    endtask

    task automatic test_output_stall;
        configure(4'hF, $urandom_range(8, 40), $urandom_range(8, 40), $urandom_range(8, 40),
                  $urandom_range(8, 40), 1'b1);
        quiet = 1'b1;
        hold_len = 80;
        run_traffic(40);
        quiet = 1'b0;
    endtask

    task automatic test_mixed;
        configure(4'($urandom), $urandom_range(0, 30), $urandom, $urandom_range(0, 30),
                  32'hFFFF_FFFF, 1'($urandom));
        run_traffic(230);
    endtask

    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            if (fault_count < 10)
                $display("mismatch on %s: expected %h, actual %h", what, want, got);
            fault_count++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin : ready_drive
        int hold_left;
        hold_left = 0;
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_len != 0)
            begin
                hold_left = hold_len;
                hold_len = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 99) < 13)
                rsp.ready <= 1'b0;
            else
                rsp.ready <= 1'b1;
        end
    end

    initial
    begin : response_check
        dccp_pkg::result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp.valid && rsp.ready)
            begin
                if (awaited_responses.size() == 0)
                begin
                    if (fault_count < 10)
                        $display("unexpected word: read_data %h", rsp.read_data);
                    fault_count++;
                end
                else
                begin
                    want = awaited_responses.pop_front();
                    compare_field("bus_error", 32'(want.bus_error), 32'(rsp.bus_error));
                    compare_field("read_data", want.read_data, rsp.read_data);
                    compare_field("xfer_start", 32'(want.xfer_start), 32'(rsp.xfer_start));
                    compare_field("xfer_is_write", 32'(want.xfer_is_write),
                                  32'(rsp.xfer_is_write));
                    compare_field("xfer_drive", 32'(want.xfer_drive), 32'(rsp.xfer_drive));
                    compare_field("xfer_sector", want.xfer_sector, rsp.xfer_sector);
                    compare_field("xfer_address", want.xfer_address, rsp.xfer_address);
                    compare_field("xfer_count", 32'(want.xfer_count), 32'(rsp.xfer_count));
                    compare_field("irq", 32'(want.irq), 32'(rsp.irq));
                end
            end
        end
    end

    initial
    begin
        #(12 * 400000);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        req.valid = 1'b0;
        req.func = dccp_pkg::FUNC_CMD_READ;
        req.write_data = 32'd0;
        req.event_drive = 2'd0;
        cfg.valid = 1'b0;
        cfg.index = dccp_pkg::CFG_DRIVE_PRESENT;
        cfg.data = 32'd0;
        present = 4'd0;
        for (int i = 0; i < 4; i++)
            sectors[i] = 32'd0;
        async_on = 1'b0;
        pa = 32'd0;
        pb = 32'd0;
        sel_valid = 1'b0;
        sel_drive = 2'd0;
        busy = 4'd0;
        done_mask = 4'd0;
        irq_en = 1'b0;
        xfer_cnt = 4'd0;
        xfer_addr = 32'd0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_sync_transfers();
        test_async_transfers();
        test_mode_switch();
        test_no_drives();
        test_output_stall();
        test_mixed();

        drain();
        repeat (10) @(posedge clk);
        if (fault_count == 0 && awaited_responses.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
